// ===== sv/gvae_pkg.sv =====
// Shared types, constants and helpers for the gravity vector attitude estimator.
// Used by gvae_divsqrt, the top level and the testbench; depends on nothing.
`default_nettype none

package gvae_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_BIAS_X   = 3'd0;
    localparam logic [2:0] REG_BIAS_Y   = 3'd1;
    localparam logic [2:0] REG_PERIOD   = 3'd2;
    localparam logic [2:0] REG_KEEP     = 3'd3;
    localparam logic [2:0] REG_MIN_MAG  = 3'd4;
    localparam logic [2:0] REG_MAX_MAG  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Fixed point constants.
    localparam logic signed [31:0] ONE_G_Q28  = 32'sd268435456;
    localparam logic signed [32:0] ATAN_C1    = 33'sd990195940;
    localparam logic signed [32:0] ATAN_C2    = -33'sd171489439;
    localparam logic signed [32:0] ATAN_C3    = -33'sd63731781;
    localparam logic [27:0]        DEG45_Q16  = 28'd2949120;
    localparam logic [27:0]        DEG180_Q16 = 28'd11796480;
    localparam logic [27:0]        DEG360_Q16 = 28'd23592960;

    // Request and response of the shared divide / square root unit.
    typedef struct packed {
        logic        start;
        logic        is_sqrt;
        logic [63:0] num;
        logic [32:0] den;
    } dv_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } dv_rsp_t;

    // Saturate a wide signed value to the 32 bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -66'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gravity_vector_attitude_estimator.sv =====
// Gravity vector attitude estimator: complementary filter with roll and pitch output.
// Depends on gvae_pkg and gvae_divsqrt.
//
// Usage. Each input item on the s_axis channel is one IMU sample: three gyro
// rates and three raw accelerometer counts. The block rotates its stored gravity
// vector by the gyro increments, blends in the normalized accelerometer vector
// when its magnitude lies inside the configured window, and returns one item on
// the m_axis channel with roll, pitch and a flag telling whether the blend ran.
// The block works on one item at a time. Its run time is set by the bit-serial
// divide and square-root unit (one square root and three divides for the blend,
// two divides for the angles) and by the single 33 x 33 multiplier that does
// every product in turn.
// s_axis_tready is high only while the sequencer is idle. A finished result sits
// in the output register, so the next item is taken even while the receiver
// stalls; the sequencer waits at its last step only if the previous result has
// still not been taken when the next one is ready.
// Reset clears the gravity estimate to one g along z and loads the register
// defaults. Configuration writes are meant for idle periods only.
`default_nettype none

module gravity_vector_attitude_estimator (
    input  wire         clk,
    input  wire         rst_n,
    // Fields from bit 0: gyro_rate_x, gyro_rate_y, gyro_rate_z,
    // accel_raw_x, accel_raw_y, accel_raw_z.
    input  wire [119:0] s_axis_tdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: roll_angle, pitch_angle, accel_applied, then zero fill.
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire         cfg_we,
    input  wire [gvae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [gvae_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Sequencer steps. M steps load the multiplier, W steps use its product.
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DM   = 5'd1;
    localparam logic [4:0] ST_DW   = 5'd2;
    localparam logic [4:0] ST_RM   = 5'd3;
    localparam logic [4:0] ST_RW   = 5'd4;
    localparam logic [4:0] ST_SM   = 5'd5;
    localparam logic [4:0] ST_SW   = 5'd6;
    localparam logic [4:0] ST_LM   = 5'd7;
    localparam logic [4:0] ST_LW   = 5'd8;
    localparam logic [4:0] ST_HM   = 5'd9;
    localparam logic [4:0] ST_HW   = 5'd10;
    localparam logic [4:0] ST_SQ   = 5'd11;
    localparam logic [4:0] ST_SQW  = 5'd12;
    localparam logic [4:0] ST_NV   = 5'd13;
    localparam logic [4:0] ST_NVW  = 5'd14;
    localparam logic [4:0] ST_BKM  = 5'd15;
    localparam logic [4:0] ST_BKW  = 5'd16;
    localparam logic [4:0] ST_BNM  = 5'd17;
    localparam logic [4:0] ST_BNW  = 5'd18;
    localparam logic [4:0] ST_AR   = 5'd19;
    localparam logic [4:0] ST_AD   = 5'd20;
    localparam logic [4:0] ST_ADW  = 5'd21;
    localparam logic [4:0] ST_PM   = 5'd22;
    localparam logic [4:0] ST_PW   = 5'd23;
    localparam logic [4:0] ST_FIN  = 5'd24;
    localparam logic [4:0] ST_OUT  = 5'd25;

    // Configuration registers.
    logic signed [15:0] bias_x_reg;
    logic signed [15:0] bias_y_reg;
    logic [23:0]        period_reg;
    logic [15:0]        keep_reg;
    logic [17:0]        min_reg;
    logic [17:0]        max_reg;

    // Sequencer and working registers.
    logic [4:0]         state_reg;
    logic [1:0]         ax_reg;
    logic [2:0]         rot_reg;
    logic [1:0]         pl_reg;
    logic               ch_reg;

    logic signed [23:0] gyro_reg [3];
    logic signed [16:0] acc_reg  [3];
    logic signed [31:0] d_reg    [3];
    logic signed [31:0] g_reg    [3];
    logic signed [65:0] p_reg;
    logic [33:0]        s_reg;
    logic [35:0]        lo_reg;
    logic               pass_reg;
    logic [29:0]        m_reg;
    logic signed [31:0] n_reg;
    logic signed [49:0] bacc_reg;
    logic [32:0]        xr_reg;
    logic [31:0]        yr_reg;
    logic [2:0]         oct_reg;
    logic [30:0]        tq_reg;
    logic signed [32:0] pp_reg;
    logic [24:0]        roll_reg;

    logic               out_valid_reg;
    logic [55:0]        out_data_reg;

    gvae_pkg::dv_req_t  dv_req;
    gvae_pkg::dv_rsp_t  dv_rsp;

    // Combinational helpers.
    logic signed [23:0] gyro_ax;
    logic signed [16:0] acc_ax;
    logic signed [31:0] g_ax;
    logic [16:0]        acc_abs;
    logic signed [31:0] rot_d;
    logic signed [31:0] rot_g;
    logic signed [31:0] rot_dst;
    logic [1:0]         rot_dst_idx;
    logic               rot_sub;
    logic signed [31:0] mq;
    logic signed [31:0] rot_new;
    logic signed [31:0] d_new;
    logic signed [31:0] blend_new;
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic signed [65:0] p_shr30;
    logic [43:0]        s_scaled;
    logic               pass_now;
    logic signed [34:0] red_x;
    logic signed [34:0] red_y;
    logic signed [34:0] red_t;
    logic [2:0]         red_oct;
    logic [27:0]        ang;
    logic               in_acc;
    logic               out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        gyro_ax = (ax_reg == 2'd0) ? gyro_reg[0] : (ax_reg == 2'd1) ? gyro_reg[1] : gyro_reg[2];
        acc_ax  = (ax_reg == 2'd0) ? acc_reg[0]  : (ax_reg == 2'd1) ? acc_reg[1]  : acc_reg[2];
        g_ax    = (ax_reg == 2'd0) ? g_reg[0]    : (ax_reg == 2'd1) ? g_reg[1]    : g_reg[2];
        acc_abs = acc_ax[16] ? 17'(-acc_ax) : 17'(acc_ax);
    end

    // Rotation order: z -= dx*x; x += dx*z; y += dy*z; z -= dy*y; x -= dz*y; y += dz*x.
    always_comb
    begin
        case (rot_reg)
            3'd0:
            begin
                rot_d = d_reg[0]; rot_g = g_reg[0]; rot_dst_idx = 2'd2; rot_sub = 1'b1;
            end
            3'd1:
            begin
                rot_d = d_reg[0]; rot_g = g_reg[2]; rot_dst_idx = 2'd0; rot_sub = 1'b0;
            end
            3'd2:
            begin
                rot_d = d_reg[1]; rot_g = g_reg[2]; rot_dst_idx = 2'd1; rot_sub = 1'b0;
            end
            3'd3:
            begin
                rot_d = d_reg[1]; rot_g = g_reg[1]; rot_dst_idx = 2'd2; rot_sub = 1'b1;
            end
            3'd4:
            begin
                rot_d = d_reg[2]; rot_g = g_reg[1]; rot_dst_idx = 2'd0; rot_sub = 1'b1;
            end
            default:
            begin
                rot_d = d_reg[2]; rot_g = g_reg[0]; rot_dst_idx = 2'd1; rot_sub = 1'b0;
            end
        endcase
        rot_dst = (rot_dst_idx == 2'd0) ? g_reg[0] : (rot_dst_idx == 2'd1) ? g_reg[1] : g_reg[2];
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        ma = 33'sd0;
        mb = 33'sd0;
        case (state_reg)
            ST_DM:
            begin
                ma = 33'(gyro_ax);
                mb = $signed({9'd0, period_reg});
            end
            ST_RM:
            begin
                ma = 33'(rot_d);
                mb = 33'(rot_g);
            end
            ST_SM:
            begin
                ma = 33'(acc_ax);
                mb = 33'(acc_ax);
            end
            ST_LM:
            begin
                ma = $signed({15'd0, min_reg});
                mb = $signed({15'd0, min_reg});
            end
            ST_HM:
            begin
                ma = $signed({15'd0, max_reg});
                mb = $signed({15'd0, max_reg});
            end
            ST_BKM:
            begin
                ma = 33'(g_ax);
                mb = $signed({17'd0, keep_reg});
            end
            ST_BNM:
            begin
                ma = 33'(n_reg);
                mb = $signed(33'(17'h10000 - {1'b0, keep_reg}));
            end
            ST_PM:
            begin
                ma = $signed({2'b00, tq_reg});
                mb = (pl_reg == 2'd0) ? gvae_pkg::ATAN_C3 : pp_reg;
            end
            default:
            begin
                ma = 33'sd0;
                mb = 33'sd0;
            end
        endcase
    end

    // Product post-processing.
    always_comb
    begin
        mq        = gvae_pkg::sat32((p_reg + 66'sd134217728) >>> 28);
        rot_new   = gvae_pkg::sat32(rot_sub ? (66'(rot_dst) - 66'(mq))
                                            : (66'(rot_dst) + 66'(mq)));
        d_new     = gvae_pkg::sat32((p_reg + 66'sd2048) >>> 12);
        blend_new = gvae_pkg::sat32((66'(bacc_reg) + p_reg + 66'sd32768) >>> 16);
        p_shr30   = p_reg >>> 30;
        s_scaled  = {s_reg, 10'd0};
        pass_now  = (s_scaled > {8'd0, lo_reg}) && (s_scaled < {8'd0, p_reg[35:0]});
    end

    // Octant reduction for the arctangent; gravity z of zero counts as one lsb.
    always_comb
    begin
        red_y   = 35'(ch_reg ? g_reg[1] : g_reg[0]);
        red_x   = (g_reg[2] == 32'sd0) ? 35'sd1 : 35'(g_reg[2]);
        red_oct = 3'd0;
        if (red_y < 35'sd0)
        begin
            red_x   = -red_x;
            red_y   = -red_y;
            red_oct = 3'd4;
        end
        if (red_x <= 35'sd0)
        begin
            red_t   = red_x;
            red_x   = red_y;
            red_y   = -red_t;
            red_oct = red_oct + 3'd2;
        end
        if (red_x <= red_y)
        begin
            red_t   = red_y - red_x;
            red_x   = red_x + red_y;
            red_y   = red_t;
            red_oct = red_oct + 3'd1;
        end
        red_t = red_y;
    end

    // Final angle: octant offset plus rounded polynomial, wrapped above 180 degrees.
    always_comb
    begin
        ang = ({25'd0, oct_reg} * gvae_pkg::DEG45_Q16)
            + 28'((pp_reg + 33'sd128) >>> 8);
        if (ang > gvae_pkg::DEG180_Q16)
        begin
            ang = ang - gvae_pkg::DEG360_Q16;
        end
    end

    // Divide / square root requests.
    always_comb
    begin
        dv_req.start   = (state_reg == ST_SQ) || (state_reg == ST_NV) || (state_reg == ST_AD);
        dv_req.is_sqrt = (state_reg == ST_SQ);
        dv_req.num     = 64'd0;
        dv_req.den     = 33'd0;
        if (state_reg == ST_SQ)
        begin
            dv_req.num = {6'd0, s_reg, 24'd0};
        end
        else if (state_reg == ST_NV)
        begin
            dv_req.num = {7'd0, acc_abs, 40'd0} + {35'd0, m_reg[29:1]};
            dv_req.den = {3'd0, m_reg};
        end
        else
        begin
            dv_req.num = {2'b00, yr_reg, 30'd0};
            dv_req.den = xr_reg;
        end
    end

    gvae_divsqrt u_divsqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dv_req),
        .rsp   (dv_rsp)
    );

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_x_reg <= 16'sd0;
            bias_y_reg <= 16'sd0;
            period_reg <= 24'd16777;
            keep_reg   <= 16'd65330;
            min_reg    <= 18'd45875;
            max_reg    <= 18'd85197;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gvae_pkg::REG_BIAS_X:  bias_x_reg <= cfg_wdata[15:0];
                gvae_pkg::REG_BIAS_Y:  bias_y_reg <= cfg_wdata[15:0];
                gvae_pkg::REG_PERIOD:  period_reg <= cfg_wdata;
                gvae_pkg::REG_KEEP:    keep_reg   <= cfg_wdata[15:0];
                gvae_pkg::REG_MIN_MAG: min_reg    <= cfg_wdata[17:0];
                gvae_pkg::REG_MAX_MAG: max_reg    <= cfg_wdata[17:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer and gravity state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ax_reg    <= 2'd0;
            rot_reg   <= 3'd0;
            pl_reg    <= 2'd0;
            ch_reg    <= 1'b0;
            g_reg[0]  <= 32'sd0;
            g_reg[1]  <= 32'sd0;
            g_reg[2]  <= gvae_pkg::ONE_G_Q28;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        ax_reg    <= 2'd0;
                        state_reg <= ST_DM;
                    end
                end
                ST_DM:  state_reg <= ST_DW;
                ST_DW:
                begin
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= 2'd0;
                        rot_reg   <= 3'd0;
                        state_reg <= ST_RM;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_DM;
                    end
                end
                ST_RM:  state_reg <= ST_RW;
                ST_RW:
                begin
                    g_reg[rot_dst_idx] <= rot_new;
                    if (rot_reg == 3'd5)
                    begin
                        ax_reg    <= 2'd0;
                        state_reg <= ST_SM;
                    end
                    else
                    begin
                        rot_reg   <= rot_reg + 3'd1;
                        state_reg <= ST_RM;
                    end
                end
                ST_SM:  state_reg <= ST_SW;
                ST_SW:
                begin
                    if (ax_reg == 2'd2)
                    begin
                        state_reg <= ST_LM;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_SM;
                    end
                end
                ST_LM:  state_reg <= ST_LW;
                ST_LW:  state_reg <= ST_HM;
                ST_HM:  state_reg <= ST_HW;
                ST_HW:
                begin
                    ax_reg    <= 2'd0;
                    ch_reg    <= 1'b0;
                    state_reg <= pass_now ? ST_SQ : ST_AR;
                end
                ST_SQ:  state_reg <= ST_SQW;
                ST_SQW:
                begin
                    if (dv_rsp.done)
                    begin
                        state_reg <= ST_NV;
                    end
                end
                ST_NV:  state_reg <= ST_NVW;
                ST_NVW:
                begin
                    if (dv_rsp.done)
                    begin
                        state_reg <= ST_BKM;
                    end
                end
                ST_BKM: state_reg <= ST_BKW;
                ST_BKW: state_reg <= ST_BNM;
                ST_BNM: state_reg <= ST_BNW;
                ST_BNW:
                begin
                    g_reg[ax_reg] <= blend_new;
                    if (ax_reg == 2'd2)
                    begin
                        ch_reg    <= 1'b0;
                        state_reg <= ST_AR;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_NV;
                    end
                end
                ST_AR:  state_reg <= ST_AD;
                ST_AD:  state_reg <= ST_ADW;
                ST_ADW:
                begin
                    if (dv_rsp.done)
                    begin
                        pl_reg    <= 2'd0;
                        state_reg <= ST_PM;
                    end
                end
                ST_PM:  state_reg <= ST_PW;
                ST_PW:
                begin
                    if (pl_reg == 2'd2)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        pl_reg    <= pl_reg + 2'd1;
                        state_reg <= ST_PM;
                    end
                end
                ST_FIN:
                begin
                    if (!ch_reg)
                    begin
                        ch_reg    <= 1'b1;
                        state_reg <= ST_AR;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers; they need no reset.
    always_ff @(posedge clk)
    begin
        p_reg <= ma * mb;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    gyro_reg[0] <= s_axis_tdata[23:0];
                    gyro_reg[1] <= s_axis_tdata[47:24];
                    gyro_reg[2] <= s_axis_tdata[71:48];
                    acc_reg[0]  <= 17'($signed(s_axis_tdata[87:72])) - 17'(bias_x_reg);
                    acc_reg[1]  <= 17'($signed(s_axis_tdata[103:88])) - 17'(bias_y_reg);
                    acc_reg[2]  <= 17'($signed(s_axis_tdata[119:104]));
                end
            end
            ST_DW:  d_reg[ax_reg] <= d_new;
            ST_SW:  s_reg <= ((ax_reg == 2'd0) ? 34'd0 : s_reg) + p_reg[33:0];
            ST_LW:  lo_reg <= p_reg[35:0];
            ST_HW:  pass_reg <= pass_now;
            ST_SQW:
            begin
                if (dv_rsp.done)
                begin
                    m_reg <= dv_rsp.quot[29:0];
                end
            end
            ST_NVW:
            begin
                if (dv_rsp.done)
                begin
                    n_reg <= acc_ax[16] ? -$signed({1'b0, dv_rsp.quot[30:0]})
                                        : $signed({1'b0, dv_rsp.quot[30:0]});
                end
            end
            ST_BKW: bacc_reg <= p_reg[49:0];
            ST_AR:
            begin
                xr_reg  <= red_x[32:0];
                yr_reg  <= red_t[31:0];
                oct_reg <= red_oct;
            end
            ST_ADW:
            begin
                if (dv_rsp.done)
                begin
                    tq_reg <= dv_rsp.quot[30:0];
                end
            end
            ST_PW:
            begin
                if (pl_reg == 2'd0)
                begin
                    pp_reg <= 33'(66'(gvae_pkg::ATAN_C2) + p_shr30);
                end
                else if (pl_reg == 2'd1)
                begin
                    pp_reg <= 33'(66'(gvae_pkg::ATAN_C1) + p_shr30);
                end
                else
                begin
                    pp_reg <= 33'(p_shr30);
                end
            end
            ST_FIN:
            begin
                if (!ch_reg)
                begin
                    roll_reg <= ang[24:0];
                end
                else
                begin
                    out_data_reg <= {5'd0, pass_reg, ang[24:0], roll_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register: holds the result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_axis_tdata <= out_data_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/gvae_divsqrt.sv =====
// Bit-serial unsigned divider and integer square root sharing one subtractor.
// Depends on gvae_pkg for the request and response structs.
`default_nettype none

module gvae_divsqrt (
    input  wire                clk,
    input  wire                rst_n,
    input  gvae_pkg::dv_req_t  req,
    output gvae_pkg::dv_rsp_t  rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic        sqrt_reg;
    logic [4:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [63:0] sh_reg;
    logic [31:0] q_reg;
    logic [32:0] den_reg;

    logic [35:0] trial_a;
    logic [35:0] trial_b;
    logic [35:0] diff;
    logic        ge;

    // Divide: one quotient bit per cycle. Square root: two radicand bits per cycle.
    always_comb
    begin
        if (sqrt_reg)
        begin
            trial_a = {rem_reg, sh_reg[63:62]};
            trial_b = {2'b00, q_reg, 2'b01};
        end
        else
        begin
            trial_a = {1'b0, rem_reg, sh_reg[63]};
            trial_b = {3'b000, den_reg};
        end
        ge   = (trial_a >= trial_b);
        diff = trial_a - trial_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sqrt_reg <= req.is_sqrt;
            den_reg  <= req.den;
            q_reg    <= 32'd0;
            if (req.is_sqrt)
            begin
                rem_reg <= 34'd0;
                sh_reg  <= req.num;
            end
            else
            begin
                rem_reg <= {2'b00, req.num[63:32]};
                sh_reg  <= {req.num[31:0], 32'd0};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[33:0] : trial_a[33:0];
            q_reg   <= {q_reg[30:0], ge};
            sh_reg  <= sqrt_reg ? {sh_reg[61:0], 2'b00} : {sh_reg[62:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

`default_nettype wire

// ===== sv/gvae_checker.sv =====
// Port-level checker for the gravity vector attitude estimator, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module gvae_checker (
    input wire         clk,
    input wire         rst_n,
    input wire [119:0] s_axis_tdata,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [55:0]  m_axis_tdata,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire         cfg_we,
    input wire [2:0]   cfg_index,
    input wire [23:0]  cfg_wdata
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // No result can appear right after an item is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after accept");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Angles stay within plus and minus 180 degrees.
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[24:0]) >= -25'sd11796480)
                       && ($signed(m_axis_tdata[24:0]) <= 25'sd11796480)
                       && ($signed(m_axis_tdata[49:25]) >= -25'sd11796480)
                       && ($signed(m_axis_tdata[49:25]) <= 25'sd11796480))
        else $error("angle out of range");

endmodule

bind gravity_vector_attitude_estimator gvae_checker u_gvae_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the gravity vector attitude estimator.
// Depends on gvae_pkg and the estimator RTL; the scoreboard carries its own predictor.
`timescale 1ns / 1ps

module testbench;
    import gvae_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int STALL_LIMIT   = 12000;
    localparam int LONG_HOLD     = 3000;
    localparam int DRAIN_CYCLES  = 400;
    localparam int ITEMS_PER_SET = 250;

    // One expected output item.
    typedef struct {
        logic [24:0] roll;
        logic [24:0] pitch;
        logic        applied;
    } attitude_t;

    // Scoreboard: keeps a bit-true copy of the estimator state and configuration,
    // predicts one output item per accepted sample and checks outputs in order.
    class attitude_scoreboard;
        longint    bias_x, bias_y, period, keep, min_mag, max_mag;
        int        grav[3];
        attitude_t pending[$];
        int        errors;
        int        blends;
        int        samples;

        function new();
            bias_x  = 0;
            bias_y  = 0;
            period  = 16777;
            keep    = 65330;
            min_mag = 45875;
            max_mag = 85197;
            grav[0] = 0;
            grav[1] = 0;
            grav[2] = ONE_G_Q28;
            errors  = 0;
            blends  = 0;
            samples = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_BIAS_X:  bias_x  = longint'($signed(val[15:0]));
                REG_BIAS_Y:  bias_y  = longint'($signed(val[15:0]));
                REG_PERIOD:  period  = longint'(val[23:0]);
                REG_KEEP:    keep    = longint'(val[15:0]);
                REG_MIN_MAG: min_mag = longint'(val[17:0]);
                REG_MAX_MAG: max_mag = longint'(val[17:0]);
                default:     ;
            endcase
        endfunction

        function int sat32(longint v);
            int r;
            if (v > 64'sd2147483647)
            begin
                r = 32'sh7fffffff;
            end
            else if (v < -64'sd2147483648)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = int'(v);
            end
            return r;
        endfunction

        // Q28 product, rounded half up, saturated.
        function int mul_q28(longint a, longint b);
            return sat32((a * b + (64'sd1 <<< 27)) >>> 28);
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned bit_w;
            r = 0;
            bit_w = 64'd1 << 62;
            while (bit_w > v)
            begin
                bit_w = bit_w >> 2;
            end
            while (bit_w != 0)
            begin
                if (v >= r + bit_w)
                begin
                    v = v - (r + bit_w);
                    r = (r >> 1) + bit_w;
                end
                else
                begin
                    r = r >> 1;
                end
                bit_w = bit_w >> 2;
            end
            return r;
        endfunction

        // Octant-reduced cubic arctangent in degrees times 65536.
        function longint angle_deg(longint y, longint x);
            longint t, oct, p, tq, r;
            oct = 0;
            if (x == 0)
            begin
                x = 1;  // a zero denominator counts as one lsb
            end
            if (y < 0)
            begin
                x = -x;
                y = -y;
                oct += 4;
            end
            if (x <= 0)
            begin
                t = x;
                x = y;
                y = -t;
                oct += 2;
            end
            if (x <= y)
            begin
                t = y - x;
                x = x + y;
                y = t;
                oct += 1;
            end
            tq = (y <<< 30) / x;
            p = longint'(ATAN_C3);
            p = longint'(ATAN_C2) + ((tq * p) >>> 30);
            p = longint'(ATAN_C1) + ((tq * p) >>> 30);
            p = (tq * p) >>> 30;
            r = oct * longint'(DEG45_Q16) + ((p + 128) >>> 8);
            if (r > longint'(DEG180_Q16))
            begin
                r -= longint'(DEG360_Q16);
            end
            return r;
        endfunction

        function void note_sample(logic [119:0] smp);
            int               dinc[3];
            longint           acc[3];
            longint           gyro, sumsq, n, blend;
            longint unsigned  mag, mq;
            longint           roll_v, pitch_v;
            attitude_t        res;
            for (int i = 0; i < 3; i++)
            begin
                gyro = longint'($signed(smp[24*i +: 24]));
                dinc[i] = sat32((gyro * period + 2048) >>> 12);
            end
            acc[0] = longint'($signed(smp[87:72])) - bias_x;
            acc[1] = longint'($signed(smp[103:88])) - bias_y;
            acc[2] = longint'($signed(smp[119:104]));

            // Small-angle rotation, each step using the freshly updated values.
            grav[2] = sat32(longint'(grav[2]) - mul_q28(dinc[0], grav[0]));
            grav[0] = sat32(longint'(mul_q28(dinc[0], grav[2])) + grav[0]);
            grav[1] = sat32(longint'(grav[1]) + mul_q28(dinc[1], grav[2]));
            grav[2] = sat32(longint'(grav[2]) - mul_q28(dinc[1], grav[1]));
            grav[0] = sat32(longint'(grav[0]) - mul_q28(dinc[2], grav[1]));
            grav[1] = sat32(longint'(mul_q28(dinc[2], grav[0])) + grav[1]);

            sumsq = acc[0] * acc[0] + acc[1] * acc[1] + acc[2] * acc[2];
            res.applied = (sumsq * 1024 > min_mag * min_mag) &&
                          (sumsq * 1024 < max_mag * max_mag);
            if (res.applied)
            begin
                mq = int_sqrt(longint'(sumsq) << 24);
                for (int i = 0; i < 3; i++)
                begin
                    mag = longint'(acc[i] < 0 ? -acc[i] : acc[i]) << 40;
                    n = longint'((mag + mq / 2) / mq);
                    if (acc[i] < 0)
                    begin
                        n = -n;
                    end
                    blend = longint'(grav[i]) * keep + n * (65536 - keep) + 32768;
                    grav[i] = sat32(blend >>> 16);
                end
                blends++;
            end
            roll_v  = angle_deg(grav[0], grav[2]);
            pitch_v = angle_deg(grav[1], grav[2]);
            res.roll  = roll_v[24:0];
            res.pitch = pitch_v[24:0];
            pending.push_back(res);
            samples++;
        endfunction

        function void check_result(logic [55:0] data);
            attitude_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected output item %h", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[24:0] !== want.roll)
            begin
                $display("%0t: roll expected %h actual %h", $time, want.roll, data[24:0]);
                errors++;
            end
            if (data[49:25] !== want.pitch)
            begin
                $display("%0t: pitch expected %h actual %h", $time, want.pitch,
                         data[49:25]);
                errors++;
            end
            if (data[50] !== want.applied)
            begin
                $display("%0t: accel_applied expected %b actual %b", $time,
                         want.applied, data[50]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic [119:0]          s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [55:0]           m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    attitude_scoreboard sb;
    int tx_idle_pct;     // chance in percent that the sender idles a cycle
    int rx_idle_pct;     // chance in percent that the receiver stalls a cycle
    int hold_count;      // remaining cycles of a long receiver hold-off
    int quiet_cycles;

    gravity_vector_attitude_estimator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Receiver: decides its ready at every falling edge. A pending hold-off keeps
    // ready low for a long stretch so the estimator backs up and stalls its input.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_count > 0)
            begin
                m_axis_tready = 1'b0;
                hold_count--;
            end
            else
            begin
                m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Output items are checked at the rising edge where they are accepted.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog: the run is stuck if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [119:0] make_sample(int gx, int gy, int gz,
                                                  int ax, int ay, int az);
        return {ax[15:0] == ax[15:0] ? az[15:0] : 16'h0, ay[15:0], ax[15:0],
                gz[23:0], gy[23:0], gx[23:0]};
    endfunction

    // Offers one sample, after random idle cycles, and returns once it is taken.
    // Valid stays high afterwards so back-to-back items need no extra assignment.
    task automatic send_sample(logic [119:0] smp);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = smp;
        s_axis_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_sample(smp);
        @(negedge clk);
    endtask

    // Waits until every predicted item has come back, with valid low.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Register writes happen only with the estimator idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val[CFG_DATA_W-1:0];
        sb.write_reg(idx, val[CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_config(int bx, int by, int per, int kp, int mn, int mx);
        write_reg(REG_BIAS_X, bx);
        write_reg(REG_BIAS_Y, by);
        write_reg(REG_PERIOD, per);
        write_reg(REG_KEEP, kp);
        write_reg(REG_MIN_MAG, mn);
        write_reg(REG_MAX_MAG, mx);
    endtask

    // Random sample: mostly a plausible IMU reading near one g with moderate
    // rates, sometimes a full-range reading that exercises every bit.
    function automatic logic [119:0] random_sample();
        int gx, gy, gz, ax, ay, az;
        if ($urandom_range(0, 99) < 80)
        begin
            gx = int'($urandom_range(0, 1310720)) - 655360;
            gy = int'($urandom_range(0, 1310720)) - 655360;
            gz = int'($urandom_range(0, 1310720)) - 655360;
            ax = int'($urandom_range(0, 1800)) - 900;
            ay = int'($urandom_range(0, 1800)) - 900;
            az = int'($urandom_range(1300, 2400));
            if ($urandom_range(0, 3) == 0)
            begin
                az = -az;
            end
        end
        else
        begin
            gx = int'($urandom);
            gy = int'($urandom);
            gz = int'($urandom);
            ax = int'($urandom);
            ay = int'($urandom);
            az = int'($urandom);
        end
        return make_sample(gx, gy, gz, ax, ay, az);
    endfunction

    task automatic random_run(int count);
        for (int i = 0; i < count; i++)
        begin
            send_sample(random_sample());
        end
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_count    = 0;
        quiet_cycles  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, reset configuration: field extremes and a level sample.
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(8388607, 8388607, 8388607, 32767, 32767, 32767));
        send_sample(make_sample(-8388608, -8388608, -8388608, -32768, -32768, -32768));
        send_sample(make_sample(0, 0, 0, 0, 0, 2048));

        // With nothing kept the estimate jumps to the accel direction: a sideways
        // one g leaves gravity z at zero, and a negative y reaches the angle wrap.
        write_reg(REG_KEEP, 0);
        send_sample(make_sample(0, 0, 0, 2048, 0, 0));
        send_sample(make_sample(0, 0, 0, -1000, -1000, -1500));
        send_sample(make_sample(0, 0, 0, 0, -2048, -10));
        send_sample(make_sample(0, 0, 0, -2048, 0, 0));

        // A zero period disables the rotation even at full rate.
        write_reg(REG_PERIOD, 0);
        send_sample(make_sample(8388607, -8388608, 8388607, 0, 0, 2048));

        // Empty window, then a magnitude sitting exactly on the lower bound.
        write_reg(REG_MIN_MAG, 65536);
        write_reg(REG_MAX_MAG, 65536);
        send_sample(make_sample(0, 0, 0, 0, 0, 2048));
        write_reg(REG_MAX_MAG, 262143);
        send_sample(make_sample(0, 0, 0, 0, 0, 2048));
        send_sample(make_sample(0, 0, 0, 0, 0, -2100));
        write_reg(REG_MIN_MAG, 0);

        // Bias extremes push the corrected accel beyond the raw range.
        write_reg(REG_BIAS_X, 32767);
        write_reg(REG_BIAS_Y, -32768);
        send_sample(make_sample(0, 0, 0, -32768, 32767, 0));
        send_sample(make_sample(0, 0, 0, 32767, -32768, 100));

        // Longest period with full rates saturates the increments.
        write_reg(REG_PERIOD, 16777215);
        write_reg(REG_KEEP, 65535);
        send_sample(make_sample(8388607, 8388607, -8388608, 0, 0, 0));
        send_sample(make_sample(-8388608, 8388607, 8388607, 100, 200, 300));

        // Writes to indexes past the last register must change nothing.
        write_reg(3'd6, 24'hffffff);
        write_reg(3'd7, 24'h123456);
        load_config(0, 0, 16777, 65330, 45875, 85197);
        send_sample(make_sample(65536, -65536, 32768, 300, -300, 2000));

        // Random part in three idle modes, two register settings in the first two and three in the last.
        tx_idle_pct = 21;
        rx_idle_pct = 78;
        random_run(ITEMS_PER_SET);
        load_config(int'($urandom_range(0, 400)) - 200, int'($urandom_range(0, 400)) - 200,
                    int'($urandom_range(1, 200000)), int'($urandom_range(0, 65535)),
                    int'($urandom_range(20000, 60000)), int'($urandom_range(70000, 140000)));
        random_run(ITEMS_PER_SET);

        tx_idle_pct = 78;
        rx_idle_pct = 21;
        load_config(-32768, 32767, 1, 65535, 0, 262143);
        random_run(ITEMS_PER_SET);
        load_config(int'($urandom_range(0, 60)) - 30, int'($urandom_range(0, 60)) - 30,
                    16777, int'($urandom_range(60000, 65535)), 45875, 85197);
        random_run(ITEMS_PER_SET);

        // No idling; a long receiver hold-off while samples keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_config(0, 0, 16777215, 0, 262143, 0);
        hold_count = LONG_HOLD;
        random_run(40);
        load_config(int'($urandom_range(0, 2000)) - 1000, int'($urandom_range(0, 2000)) - 1000,
                    int'($urandom_range(1, 16777215)), int'($urandom_range(0, 65535)),
                    int'($urandom_range(0, 262143)), int'($urandom_range(0, 262143)));
        random_run(ITEMS_PER_SET);
        load_config(0, 0, 16777, 65330, 45875, 85197);
        random_run(ITEMS_PER_SET - 40);

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d samples, %0d with the accel blend, under reset, extreme", 
                 sb.samples, sb.blends);
        $display("and random register settings with sender and receiver idling.");
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/gvae_pkg.sv
sv/gvae_divsqrt.sv
sv/gravity_vector_attitude_estimator.sv
sv/gvae_checker.sv
test/testbench.sv
